/* rtl/core/pswv_pkg.sv */
// ---------------------------------------------------------------------------
// pswv_pkg: shared types and constants for the plane swirl velocity warp
// Fixed-point formats, CORDIC arctangent table, swirl kinds, register map
// and the latency helpers used to line up the pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package pswv_pkg;

  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int COORD_FRAC_BITS_DEF = 12;
  localparam int SWIRL_FRAC          = 12;

  // sin/cos results are Q30 held in 32 bits, CORDIC datapath a little wider
  localparam int Q_W  = 32;
  localparam int XY_W = 33;
  localparam int Z_W  = 33;

  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] GAIN_Q30    = 32'd652032874;
  localparam logic [31:0] Q30_ONE     = 32'd1073741824;

  localparam int ATAN_ENTRIES = 24;

  typedef enum logic [2:0] {
    KIND_NONE        = 3'd0,
    KIND_SIN_CURL    = 3'd1,
    KIND_COS_CURL    = 3'd2,
    KIND_SIN_COS     = 3'd3,
    KIND_COS_SIN     = 3'd4,
    KIND_SIN_OF_COS  = 3'd5,
    KIND_COS_OF_SIN  = 3'd6
  } swirl_kind_t;

  typedef enum logic [2:0] {
    REG_PLANE_AMP_X  = 3'd0,
    REG_PLANE_AMP_Y  = 3'd1,
    REG_SWIRL_KIND   = 3'd2,
    REG_SWIRL_FREQ_X = 3'd3,
    REG_SWIRL_FREQ_Y = 3'd4,
    REG_SWIRL_AMP_X  = 3'd5,
    REG_SWIRL_AMP_Y  = 3'd6
  } cfg_reg_t;

  // quadrant bookkeeping carried alongside an angle
  typedef struct packed {
    logic neg;   // angle was negative
    logic odd;   // odd multiple of pi removed
    logic flip;  // folded about pi/2
  } sc_flags_t;

  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'd843314857;
      1:  v = 32'd497837829;
      2:  v = 32'd263043837;
      3:  v = 32'd133525159;
      4:  v = 32'd67021687;
      5:  v = 32'd33543516;
      6:  v = 32'd16775851;
      7:  v = 32'd8388437;
      8:  v = 32'd4194283;
      9:  v = 32'd2097149;
      10: v = 32'd1048576;
      11: v = 32'd524288;
      12: v = 32'd262144;
      13: v = 32'd131072;
      14: v = 32'd65536;
      15: v = 32'd32768;
      16: v = 32'd16384;
      17: v = 32'd8192;
      18: v = 32'd4096;
      19: v = 32'd2048;
      20: v = 32'd1024;
      21: v = 32'd512;
      22: v = 32'd256;
      23: v = 32'd128;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [Q_W-1:0] clamp_unit(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] one;
    logic signed [Q_W-1:0]  r;
    one = XY_W'(Q30_ONE);
    if (v > one) r = Q_W'(one);
    else if (v < -one) r = -Q_W'(one);
    else r = Q_W'(v);
    return r;
  endfunction

  // width of an angle magnitude for a given coordinate format
  function automatic int ang_width(input int cfb);
    int sh;
    sh = 30 - (cfb + SWIRL_FRAC);
    return (sh > 0) ? 32 + sh : 32;
  endfunction

  // compare-subtract steps needed to reduce an angle of width aw modulo pi
  function automatic int red_steps(input int aw);
    return (aw > 31) ? aw - 31 : 1;
  endfunction

  function automatic int sc_latency(input int aw, input int stages);
    return red_steps(aw) + stages + 2;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/pswv_reduce_cell.sv */
// ---------------------------------------------------------------------------
// pswv_reduce_cell: one step of the modulo-pi range reduction
// Takes pi*2^STEP off the remainder when it fits; the last step records
// the parity of the quotient.
// ---------------------------------------------------------------------------
`default_nettype none

module pswv_reduce_cell #(
  parameter int AW   = 38,
  parameter int STEP = 0
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [AW-1:0]      rem_in,
  input  wire pswv_pkg::sc_flags_t flags_in,
  output      logic [AW-1:0]      rem_out,
  output      pswv_pkg::sc_flags_t flags_out
);

  localparam logic [AW-1:0] PI_SH = AW'(pswv_pkg::PI_Q30) << STEP;

  logic                ge;
  pswv_pkg::sc_flags_t flags_next;

  assign ge = (rem_in >= PI_SH);

  always_comb begin
    flags_next = flags_in;
    if (STEP == 0) flags_next.odd = ge;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out   <= ge ? rem_in - PI_SH : rem_in;
      flags_out <= flags_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pswv_cordic_cell.sv */
// ---------------------------------------------------------------------------
// pswv_cordic_cell: one CORDIC rotation step
// Rotates (x, y) by +/- atan(2^-IDX) towards a residual angle of zero.
// ---------------------------------------------------------------------------
`default_nettype none

module pswv_cordic_cell #(
  parameter int IDX = 0
) (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [pswv_pkg::XY_W-1:0]   x_in,
  input  wire logic signed [pswv_pkg::XY_W-1:0]   y_in,
  input  wire logic signed [pswv_pkg::Z_W-1:0]    z_in,
  input  wire pswv_pkg::sc_flags_t                 flags_in,
  output      logic signed [pswv_pkg::XY_W-1:0]   x_out,
  output      logic signed [pswv_pkg::XY_W-1:0]   y_out,
  output      logic signed [pswv_pkg::Z_W-1:0]    z_out,
  output      pswv_pkg::sc_flags_t                 flags_out
);

  logic signed [pswv_pkg::XY_W-1:0] dx;
  logic signed [pswv_pkg::XY_W-1:0] dy;
  logic signed [pswv_pkg::Z_W-1:0]  at;

  assign dx = y_in >>> IDX;
  assign dy = x_in >>> IDX;
  assign at = pswv_pkg::Z_W'(pswv_pkg::atan_q30(IDX));

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[pswv_pkg::Z_W-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - at;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + at;
      end
      flags_out <= flags_in;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pswv_sincos.sv */
// ---------------------------------------------------------------------------
// pswv_sincos: pipelined sine and cosine of a sign-magnitude Q30 angle
// Reduction cells modulo pi, a fold about pi/2, a row of CORDIC cells, then
// clamping and quadrant signs.
// ---------------------------------------------------------------------------
`default_nettype none

module pswv_sincos #(
  parameter int AW     = 38,
  parameter int STAGES = 16
) (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic [AW-1:0]                      mag,
  input  wire logic                               neg,
  output      logic signed [pswv_pkg::Q_W-1:0]    sin_q,
  output      logic signed [pswv_pkg::Q_W-1:0]    cos_q
);

  localparam int QB = pswv_pkg::red_steps(AW);

  logic [AW-1:0]        rem [QB+1];
  pswv_pkg::sc_flags_t  rfl [QB+1];

  logic signed [pswv_pkg::XY_W-1:0] xs [STAGES+1];
  logic signed [pswv_pkg::XY_W-1:0] ys [STAGES+1];
  logic signed [pswv_pkg::Z_W-1:0]  zs [STAGES+1];
  pswv_pkg::sc_flags_t               cfl [STAGES+1];

  logic [31:0]                       r_lo;
  logic                              fold;
  logic signed [pswv_pkg::Q_W-1:0]   s_cl;
  logic signed [pswv_pkg::Q_W-1:0]   c_cl;

  assign rem[0]      = mag;
  assign rfl[0].neg  = neg;
  assign rfl[0].odd  = 1'b0;
  assign rfl[0].flip = 1'b0;

  for (genvar j = 0; j < QB; j++) begin : g_red
    pswv_reduce_cell #(.AW(AW), .STEP(QB - 1 - j)) u_cell (
      .clk      (clk),
      .en       (en),
      .rem_in   (rem[j]),
      .flags_in (rfl[j]),
      .rem_out  (rem[j+1]),
      .flags_out(rfl[j+1])
    );
  end

  // remainder is below pi here, so 32 bits hold it
  assign r_lo = rem[QB][31:0];
  assign fold = (r_lo > pswv_pkg::HALF_PI_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      cfl[0] <= '{neg: rfl[QB].neg, odd: rfl[QB].odd, flip: fold};
      zs[0]  <= fold ? pswv_pkg::Z_W'(pswv_pkg::PI_Q30 - r_lo) : pswv_pkg::Z_W'(r_lo);
    end
  end

  assign xs[0] = pswv_pkg::XY_W'(pswv_pkg::GAIN_Q30);
  assign ys[0] = '0;

  for (genvar i = 0; i < STAGES; i++) begin : g_cordic
    pswv_cordic_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .en       (en),
      .x_in     (xs[i]),
      .y_in     (ys[i]),
      .z_in     (zs[i]),
      .flags_in (cfl[i]),
      .x_out    (xs[i+1]),
      .y_out    (ys[i+1]),
      .z_out    (zs[i+1]),
      .flags_out(cfl[i+1])
    );
  end

  assign s_cl = pswv_pkg::clamp_unit(ys[STAGES]);
  assign c_cl = pswv_pkg::clamp_unit(xs[STAGES]);

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q <= (cfl[STAGES].odd ^ cfl[STAGES].neg)  ? -s_cl : s_cl;
      cos_q <= (cfl[STAGES].odd ^ cfl[STAGES].flip) ? -c_cl : c_cl;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/plane_swirl_velocity_warp_unit.sv */
// ---------------------------------------------------------------------------
// plane_swirl_velocity_warp_unit: per-pixel plane and swirl velocity warp
// One pixel in, one warped velocity pair out; fully pipelined.
// ---------------------------------------------------------------------------
// Takes one pixel per clock while s_tready is high and returns one result
// per pixel, in order. The path runs through the two sine/cosine units in
// series, each a row of reduction and CORDIC cells. Throughput is one
// pixel per cycle; a two-entry output buffer lets the pipeline keep moving
// through a downstream stall until a second result is waiting, after which
// s_tready drops until the output register makes a transfer. Configuration
// registers must only be written while the pipeline is empty.
`default_nettype none

module plane_swirl_velocity_warp_unit #(
  parameter int CORDIC_STAGES   = pswv_pkg::CORDIC_STAGES_DEF,
  parameter int COORD_FRAC_BITS = pswv_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [63:0] s_tdata,   // coord_x, coord_y, vel_x, vel_y
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [31:0] m_tdata,   // new_vel_x, new_vel_y
  output      logic [0:0]  m_tuser,   // saturated
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  localparam int AW1   = pswv_pkg::ang_width(COORD_FRAC_BITS);
  localparam int AW2   = 32;
  localparam int L1    = pswv_pkg::sc_latency(AW1, CORDIC_STAGES);
  localparam int L2    = pswv_pkg::sc_latency(AW2, CORDIC_STAGES);
  localparam int DEPTH = 9 + L1 + L2;
  localparam int ANG_SH = 30 - (COORD_FRAC_BITS + pswv_pkg::SWIRL_FRAC);
  localparam int CS    = 30 - COORD_FRAC_BITS;
  localparam int RS    = 50 - COORD_FRAC_BITS;
  localparam int SUM_W = 40;

  // configuration
  logic signed [23:0] plane_amp [2];
  logic [16:0]        swirl_freq [2];
  logic [16:0]        swirl_amp [2];
  logic [2:0]         swirl_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_amp[0]  <= '0;
      plane_amp[1]  <= '0;
      swirl_kind    <= pswv_pkg::KIND_NONE;
      swirl_freq[0] <= 17'd4096;
      swirl_freq[1] <= 17'd4096;
      swirl_amp[0]  <= 17'd4096;
      swirl_amp[1]  <= 17'd4096;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pswv_pkg::REG_PLANE_AMP_X:  plane_amp[0]  <= cfg_data;
        pswv_pkg::REG_PLANE_AMP_Y:  plane_amp[1]  <= cfg_data;
        pswv_pkg::REG_SWIRL_KIND:   swirl_kind    <= cfg_data[2:0];
        pswv_pkg::REG_SWIRL_FREQ_X: swirl_freq[0] <= cfg_data[16:0];
        pswv_pkg::REG_SWIRL_FREQ_Y: swirl_freq[1] <= cfg_data[16:0];
        pswv_pkg::REG_SWIRL_AMP_X:  swirl_amp[0]  <= cfg_data[16:0];
        pswv_pkg::REG_SWIRL_AMP_Y:  swirl_amp[1]  <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic             adv;
  logic [DEPTH-1:0] v;
  logic             p_fire;
  logic             skid_valid;

  assign adv      = ~skid_valid;
  assign s_tready = adv & ~rst;
  assign p_fire   = adv & v[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[DEPTH-2:0], s_tvalid};
    end
  end

  // lane 0 gives new_vel_x from coord_y, lane 1 gives new_vel_y from coord_x
  logic signed [15:0] res [2];
  logic               res_sat [2];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [15:0] coord_d [DEPTH];
    logic signed [15:0] vel_d [DEPTH];
    logic signed [33:0] ang_prod;
    logic [31:0]        ang_abs;
    logic [AW1-1:0]     ang_mag_sh;
    logic [AW1-1:0]     ang_mag;
    logic               ang_neg;
    logic signed [pswv_pkg::Q_W-1:0] s1;
    logic signed [pswv_pkg::Q_W-1:0] c1;
    logic signed [pswv_pkg::Q_W-1:0] s2;
    logic signed [pswv_pkg::Q_W-1:0] c2;
    logic signed [pswv_pkg::Q_W-1:0] fac1_d [L2+2];
    logic signed [pswv_pkg::Q_W-1:0] fac1_next;
    logic signed [pswv_pkg::Q_W-1:0] pi_sel;
    logic signed [63:0] pim_prod;
    logic signed [63:0] pim_sh;
    logic signed [32:0] pv;
    logic [31:0]        pv_mag;
    logic               pv_neg;
    logic signed [pswv_pkg::Q_W-1:0] fac;
    logic signed [pswv_pkg::Q_W-1:0] fac_next;
    logic signed [49:0] off_prod;
    logic signed [37:0] off;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [63:0] eff_prod;
    logic signed [63:0] eff;
    logic signed [64:0] rsum;
    logic signed [15:0] r_out;
    logic               r_sat;

    always_ff @(posedge clk) begin
      if (adv) begin
        coord_d[0] <= (l == 0) ? s_tdata[31:16] : s_tdata[15:0];
        vel_d[0]   <= (l == 0) ? s_tdata[47:32] : s_tdata[63:48];
        for (int k = 1; k < DEPTH; k++) begin
          coord_d[k] <= coord_d[k-1];
          vel_d[k]   <= vel_d[k-1];
        end
      end
    end

    // swirl angle: coord * freq taken to Q30
    assign ang_prod = 34'(coord_d[0]) * 34'($signed({1'b0, swirl_freq[l]}));
    assign ang_abs  = ang_prod[33] ? 32'(-ang_prod) : ang_prod[31:0];

    if (ANG_SH >= 0) begin : g_shl
      assign ang_mag_sh = AW1'(ang_abs) << ANG_SH;
    end else begin : g_shr
      assign ang_mag_sh = AW1'(ang_abs >> (-ANG_SH));
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ang_mag <= ang_mag_sh;
        // an angle truncated to zero counts as positive
        ang_neg <= ang_prod[33] & (ang_mag_sh != '0);
      end
    end

    pswv_sincos #(.AW(AW1), .STAGES(CORDIC_STAGES)) u_sc1 (
      .clk  (clk),
      .en   (adv),
      .mag  (ang_mag),
      .neg  (ang_neg),
      .sin_q(s1),
      .cos_q(c1)
    );

    always_comb begin
      pi_sel = (swirl_kind == pswv_pkg::KIND_SIN_OF_COS) ? c1 : s1;
      case (swirl_kind)
        pswv_pkg::KIND_SIN_CURL, pswv_pkg::KIND_SIN_COS: fac1_next = (l == 0) ? s1 : c1;
        pswv_pkg::KIND_COS_CURL, pswv_pkg::KIND_COS_SIN: fac1_next = (l == 0) ? c1 : s1;
        default: fac1_next = '0;
      endcase
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pim_prod  <= 64'(pi_sel) * 64'($signed({1'b0, pswv_pkg::PI_Q30}));
        fac1_d[0] <= fac1_next;
        for (int k = 1; k < L2 + 2; k++) fac1_d[k] <= fac1_d[k-1];
      end
    end

    // pi times a unit value, floor back to Q30; magnitude never exceeds pi
    assign pim_sh = pim_prod >>> 30;
    assign pv     = pim_sh[32:0];

    always_ff @(posedge clk) begin
      if (adv) begin
        pv_neg <= pv[32];
        pv_mag <= pv[32] ? 32'(-pv) : pv[31:0];
      end
    end

    pswv_sincos #(.AW(AW2), .STAGES(CORDIC_STAGES)) u_sc2 (
      .clk  (clk),
      .en   (adv),
      .mag  (pv_mag),
      .neg  (pv_neg),
      .sin_q(s2),
      .cos_q(c2)
    );

    always_comb begin
      case (swirl_kind)
        pswv_pkg::KIND_SIN_OF_COS: fac_next = (l == 0) ? s2 : c2;
        pswv_pkg::KIND_COS_OF_SIN: fac_next = (l == 0) ? c2 : s2;
        default:                   fac_next = fac1_d[L2+1];
      endcase
    end

    assign off      = 38'(off_prod >>> pswv_pkg::SWIRL_FRAC);
    assign sum_next = (SUM_W'(coord_d[DEPTH-4]) <<< CS) + SUM_W'(off);
    assign eff      = eff_prod >>> RS;
    assign rsum     = 65'(eff) + 65'(vel_d[DEPTH-2]);

    always_comb begin
      r_sat = 1'b0;
      r_out = rsum[15:0];
      if (rsum > 65'sd32767) begin
        r_out = 16'sh7fff;
        r_sat = 1'b1;
      end else if (rsum < -65'sd32768) begin
        r_out = 16'sh8000;
        r_sat = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        fac        <= fac_next;
        off_prod   <= 50'($signed({1'b0, swirl_amp[l]})) * 50'(fac);
        sum        <= sum_next;
        eff_prod   <= 64'(sum) * 64'(plane_amp[l]);
        res[l]     <= r_out;
        res_sat[l] <= r_sat;
      end
    end
  end

  // output register with one skid entry
  logic [15:0] out_nx, out_ny, skid_nx, skid_ny;
  logic        out_sat, skid_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid   <= p_fire;
      end
    end else if (p_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        out_nx  <= skid_nx;
        out_ny  <= skid_ny;
        out_sat <= skid_sat;
      end else begin
        out_nx  <= res[0];
        out_ny  <= res[1];
        out_sat <= res_sat[0] | res_sat[1];
      end
    end else if (p_fire) begin
      skid_nx  <= res[0];
      skid_ny  <= res[1];
      skid_sat <= res_sat[0] | res_sat[1];
    end
  end

  assign m_tdata = {out_ny, out_nx};
  assign m_tuser = out_sat;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry held while output register empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !m_tready |=> skid_valid)
    else $error("skid entry lost without an output transfer");

  a_out_drains: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !skid_valid && !p_fire |=> !m_tvalid)
    else $error("output valid without a source");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      m_tdata[15:0] == 16'h7fff || m_tdata[15:0] == 16'h8000 ||
      m_tdata[31:16] == 16'h7fff || m_tdata[31:16] == 16'h8000)
    else $error("saturation flag set with no clipped result");

endmodule

`default_nettype wire
